// ----- hw/rtl/crff_pkg.sv -----
package crff_pkg;

  // Command codes carried on func
  typedef enum logic [1:0] {
    FUNC_SET   = 2'd0,
    FUNC_FILL  = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Field widths fixed by the command format
  localparam int unsigned POS_W  = 16;
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned REG_W  = 9;
  localparam int unsigned COLOR_W = 24;

  // Signed width for clip math: 16-bit position plus 15-bit size, with headroom
  localparam int unsigned CLIP_W = 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_WORK,
    ST_RDW,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/clipped_rect_fill_framebuffer.sv -----
// Sequence: a command goes IDLE, CALC, MUL, WORK, DONE; a read adds RDW after WORK,
//   and an empty clip goes from CALC straight to DONE, which waits while an earlier
//   result sits stalled in the output register.
// Throughput: one command at a time; the next command is accepted the cycle after the
//   result loads. Pixel writes go through the single frame memory write port at one
//   pixel per cycle, so fill rate is set by that port.
// Reset: rst (sync, active high) clears the FSM, the output valid and both size
//   registers, and holds both input channels off; the frame memory is not cleared
//   and reads undefined until written.
module clipped_rect_fill_framebuffer
  import crff_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [REG_W-1:0]         cfg_data,
  // command channel
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               func,
  input  logic [7:0]               red,
  input  logic [7:0]               green,
  input  logic [7:0]               blue,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic [SIZE_W-1:0]        rect_width,
  input  logic [SIZE_W-1:0]        rect_height,
  // result channel
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [7:0]               read_red,
  output logic [7:0]               read_green,
  output logic [7:0]               read_blue,
  output logic                     inside_res
);

  // Column / row index widths, and width able to hold the size itself
  localparam int unsigned XW    = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Row base register must also hold eff_w for the add on row advance
  localparam int unsigned BW    = (AW > WW) ? AW : WW;
  localparam int unsigned PW    = YW + WW;

  // ------------------------------------------------------------------
  // Size registers, saturated to the memory geometry
  // ------------------------------------------------------------------
  logic [REG_W-1:0] image_width;
  logic [REG_W-1:0] image_height;
  logic [WW-1:0]    eff_w;
  logic [HW-1:0]    eff_h;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= '0;
      image_height <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (32'(image_width) > MAX_WIDTH) eff_w = WW'(MAX_WIDTH);
    else                              eff_w = WW'(image_width);
    if (32'(image_height) > MAX_HEIGHT) eff_h = HW'(MAX_HEIGHT);
    else                                eff_h = HW'(image_height);
  end

  // ------------------------------------------------------------------
  // Command capture
  // ------------------------------------------------------------------
  func_t                   func_q;
  logic [COLOR_W-1:0]      color_q;
  logic signed [POS_W-1:0] x_q;
  logic signed [POS_W-1:0] y_q;
  logic [SIZE_W-1:0]       w_q;
  logic [SIZE_W-1:0]       h_q;

  state_t state;
  state_t state_next;

  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_q  <= func_t'(func);
      color_q <= {red, green, blue};
      x_q     <= pos_x;
      y_q     <= pos_y;
      w_q     <= rect_width;
      h_q     <= rect_height;
    end
  end

  // ------------------------------------------------------------------
  // Clip: set and read are a 1x1 fill, clear is a full-image fill
  // ------------------------------------------------------------------
  logic signed [CLIP_W-1:0] xs, ys, wsz, hsz, ew_s, eh_s;
  logic signed [CLIP_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic                     span_ok;

  always_comb begin
    ew_s = signed'(CLIP_W'(eff_w));
    eh_s = signed'(CLIP_W'(eff_h));
    case (func_q)
      FUNC_FILL: begin
        xs  = CLIP_W'(x_q);
        ys  = CLIP_W'(y_q);
        wsz = signed'(CLIP_W'(w_q));
        hsz = signed'(CLIP_W'(h_q));
      end
      FUNC_CLEAR: begin
        xs  = '0;
        ys  = '0;
        wsz = ew_s;
        hsz = eh_s;
      end
      default: begin
        xs  = CLIP_W'(x_q);
        ys  = CLIP_W'(y_q);
        wsz = CLIP_W'(1);
        hsz = CLIP_W'(1);
      end
    endcase
    lo_x = (xs < 0) ? '0 : xs;
    lo_y = (ys < 0) ? '0 : ys;
    hi_x = xs + wsz;
    hi_y = ys + hsz;
    if (hi_x > ew_s) hi_x = ew_s;
    if (hi_y > eh_s) hi_y = eh_s;
    span_ok = (lo_x < hi_x) && (lo_y < hi_y);
  end

  // ------------------------------------------------------------------
  // Walk registers
  // ------------------------------------------------------------------
  logic [XW-1:0] col_lo;
  logic [XW:0]   col_hi;
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [YW:0]   row_hi;
  logic [BW-1:0] base;
  logic          hit;
  logic [PW-1:0] prod;
  logic          col_last;
  logic          row_last;

  assign prod     = PW'(row) * PW'(eff_w);
  assign col_last = ((XW+1)'(col) + (XW+1)'(1)) == col_hi;
  assign row_last = ((YW+1)'(row) + (YW+1)'(1)) == row_hi;

  always_ff @(posedge clk) begin
    case (state)
      ST_CALC: begin
        col_lo <= lo_x[XW-1:0];
        col    <= lo_x[XW-1:0];
        col_hi <= hi_x[XW:0];
        row    <= lo_y[YW-1:0];
        row_hi <= hi_y[YW:0];
        hit    <= span_ok;
      end
      ST_MUL: begin
        base <= prod[BW-1:0];
      end
      ST_WORK: begin
        if (func_q != FUNC_READ) begin
          if (!col_last) begin
            col <= col + XW'(1);
          end else if (!row_last) begin
            col  <= col_lo;
            row  <= row + YW'(1);
            base <= base + BW'(eff_w);
          end
        end
      end
      default: ;
    endcase
  end

  // ------------------------------------------------------------------
  // Frame memory: one write port, one registered read port
  // ------------------------------------------------------------------
  logic [COLOR_W-1:0] frame_mem [DEPTH];
  logic [COLOR_W-1:0] rd_q;
  logic [AW-1:0]      addr;
  logic               mem_we;
  logic               mem_re;

  assign addr = base[AW-1:0] + AW'(col);

  always_ff @(posedge clk) begin
    if (mem_we) frame_mem[addr] <= color_q;
    if (mem_re) rd_q <= frame_mem[addr];
  end

  // ------------------------------------------------------------------
  // Control FSM
  // ------------------------------------------------------------------
  logic out_load;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        // no command taken while reset is held
        in_stall = rst;
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        // empty clip skips the memory entirely
        state_next = span_ok ? ST_MUL : ST_DONE;
      end
      ST_MUL: begin
        state_next = ST_WORK;
      end
      ST_WORK: begin
        if (func_q == FUNC_READ) begin
          mem_re     = 1'b1;
          state_next = ST_RDW;
        end else begin
          mem_we = 1'b1;
          if (col_last && row_last) state_next = ST_DONE;
        end
      end
      ST_RDW: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (func_q == FUNC_READ && hit) begin
        read_red   <= rd_q[23:16];
        read_green <= rd_q[15:8];
        read_blue  <= rd_q[7:0];
      end else begin
        read_red   <= '0;
        read_green <= '0;
        read_blue  <= '0;
      end
      inside_res <= hit && (func_q == FUNC_SET || func_q == FUNC_READ);
    end
  end

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------
  a_walk_in_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_WORK |-> ({1'b0, col} < col_hi) && ({1'b0, row} < row_hi))
    else $error("walk outside clipped span");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> 32'(addr) < DEPTH)
    else $error("frame write address beyond memory");

  a_rdw_after_read: assert property (@(posedge clk) disable iff (rst)
    state == ST_RDW |-> $past(state) == ST_WORK && $past(mem_re))
    else $error("read wait without a read issued");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DONE)
    else $error("result appeared outside done state");

  a_no_write_on_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> func_q != FUNC_READ && !mem_re)
    else $error("memory write during read command");

endmodule
